// File: rtl/tcd_pkg.sv
`default_nettype none
package tcd_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int MAX_PASSES  = 8;

   localparam int DIM_W       = 9;
   localparam int PASS_REG_W  = 4;
   localparam int ACT_P_W     = $clog2(MAX_PASSES + 1);
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int POS_W       = 17;
   localparam int CSR_INDEX_W = 2;

   localparam int FIFO_DEPTH  = 32;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

   localparam int SUM_W       = 12;
   localparam int NCNT_W      = 4;
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_PASS_COUNT   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic      first;
      pixel_type pixel;
   } token_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             enable;
   } cell_cfg_type;

   // ceil(2^16 / n), exact floor division for sums below 2^16 / 9
   function automatic logic [RECIP_W-1:0] recip(input logic [NCNT_W-1:0] n);
      logic [RECIP_W-1:0] r;
      case (n)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         4'd9:    r = 17'd7282;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/tcd_ram.sv
`default_nettype none
module tcd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// File: rtl/tcd_cell.sv
`default_nettype none
module tcd_cell
   import tcd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_cfg_type cfg,
   input  wire logic         in_valid,
   input  wire token_type    in_tok,
   output logic              out_valid,
   output token_type         out_tok
);

   // input side counters
   logic [COL_W-1:0] col_ff, col_a;
   logic [DIM_W-1:0] cnt_ff, cnt_a;
   logic [COL_W-1:0] qx_ff, qx_a;
   logic [ROW_W-1:0] qy_ff, qy_a;
   logic             emit_a, first_out_a;

   assign col_a       = in_tok.first ? '0 : col_ff;
   assign cnt_a       = in_tok.first ? '0 : cnt_ff;
   assign qx_a        = in_tok.first ? '0 : qx_ff;
   assign qy_a        = in_tok.first ? '0 : qy_ff;
   assign emit_a      = cnt_a > cfg.width;
   assign first_out_a = cnt_a == (cfg.width + DIM_W'(1));

   // stage a
   logic             a_valid_ff, a_emit_ff, a_first_out_ff, a_in_first_ff;
   pixel_type        a_pixel_ff;
   logic [COL_W-1:0] a_col_ff, a_qx_ff;
   logic [ROW_W-1:0] a_qy_ff;

   logic [63:0] rd_data;

   tcd_ram #(.WIDTH(64), .DEPTH(MAX_WIDTH)) u_lines (
      .clock   (clock),
      .wr_en   (a_valid_ff),
      .wr_addr (a_col_ff),
      .wr_data ({rd_data[31:0], a_pixel_ff}),
      .rd_addr (col_a),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      if (in_valid) begin
         a_pixel_ff     <= in_tok.pixel;
         a_in_first_ff  <= in_tok.first;
         a_emit_ff      <= emit_a;
         a_first_out_ff <= first_out_a;
         a_col_ff       <= col_a;
         a_qx_ff        <= qx_a;
         a_qy_ff        <= qy_a;
         if (DIM_W'(col_a) == cfg.width - DIM_W'(1)) begin
            col_ff <= '0;
         end else begin
            col_ff <= col_a + COL_W'(1);
         end
         if (cnt_a == cfg.width + DIM_W'(2)) begin
            cnt_ff <= cnt_a;
         end else begin
            cnt_ff <= cnt_a + DIM_W'(1);
         end
         qx_ff <= qx_a;
         qy_ff <= qy_a;
         if (emit_a) begin
            if (DIM_W'(qx_a) == cfg.width - DIM_W'(1)) begin
               qx_ff <= '0;
               qy_ff <= qy_a + ROW_W'(1);
            end else begin
               qx_ff <= qx_a + COL_W'(1);
            end
         end
      end
   end

   // stage b: 3x3 window shift
   pixel_type        win_ff [3][3];
   logic             b_valid_ff, b_emit_ff, b_first_out_ff, b_in_first_ff;
   pixel_type        b_pixel_ff;
   logic [COL_W-1:0] b_qx_ff;
   logic [ROW_W-1:0] b_qy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      if (a_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2]   <= rd_data[63:32];
         win_ff[1][2]   <= rd_data[31:0];
         win_ff[2][2]   <= a_pixel_ff;
         b_pixel_ff     <= a_pixel_ff;
         b_emit_ff      <= a_emit_ff;
         b_first_out_ff <= a_first_out_ff;
         b_in_first_ff  <= a_in_first_ff;
         b_qx_ff        <= a_qx_ff;
         b_qy_ff        <= a_qy_ff;
      end
   end

   // stage c: masked sums
   logic              row_ok [3];
   logic              col_ok [3];
   logic [SUM_W-1:0]  sum_r, sum_g, sum_b;
   logic [NCNT_W-1:0] n_sum;

   always_comb begin
      row_ok[0] = b_qy_ff != '0;
      row_ok[1] = 1'b1;
      row_ok[2] = (DIM_W'(b_qy_ff) + DIM_W'(1)) < cfg.height;
      col_ok[0] = b_qx_ff != '0;
      col_ok[1] = 1'b1;
      col_ok[2] = (DIM_W'(b_qx_ff) + DIM_W'(1)) < cfg.width;
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      n_sum = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (row_ok[r] && col_ok[c] && (win_ff[r][c] != '0)) begin
               sum_r = sum_r + SUM_W'(win_ff[r][c].red);
               sum_g = sum_g + SUM_W'(win_ff[r][c].green);
               sum_b = sum_b + SUM_W'(win_ff[r][c].blue);
               n_sum = n_sum + NCNT_W'(1);
            end
         end
      end
   end

   logic              c_valid_ff, c_emit_ff, c_first_out_ff, c_in_first_ff;
   pixel_type         c_pixel_ff, c_centre_ff;
   logic [SUM_W-1:0]  c_sum_r_ff, c_sum_g_ff, c_sum_b_ff;
   logic [NCNT_W-1:0] c_n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      if (b_valid_ff) begin
         c_pixel_ff     <= b_pixel_ff;
         c_centre_ff    <= win_ff[1][1];
         c_emit_ff      <= b_emit_ff;
         c_first_out_ff <= b_first_out_ff;
         c_in_first_ff  <= b_in_first_ff;
         c_sum_r_ff     <= sum_r;
         c_sum_g_ff     <= sum_g;
         c_sum_b_ff     <= sum_b;
         c_n_ff         <= n_sum;
      end
   end

   // stage d: divide by reciprocal multiply
   logic [RECIP_W-1:0]       rc;
   logic [SUM_W+RECIP_W-1:0] prod_r, prod_g, prod_b;
   pixel_type                avg;

   always_comb begin
      rc        = recip(c_n_ff);
      prod_r    = (SUM_W+RECIP_W)'(c_sum_r_ff) * (SUM_W+RECIP_W)'(rc);
      prod_g    = (SUM_W+RECIP_W)'(c_sum_g_ff) * (SUM_W+RECIP_W)'(rc);
      prod_b    = (SUM_W+RECIP_W)'(c_sum_b_ff) * (SUM_W+RECIP_W)'(rc);
      avg.alpha = 8'd0;
      avg.red   = prod_r[RECIP_SHIFT +: 8];
      avg.green = prod_g[RECIP_SHIFT +: 8];
      avg.blue  = prod_b[RECIP_SHIFT +: 8];
   end

   logic      d_valid_ff;
   token_type d_tok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff && (!cfg.enable || c_emit_ff);
      end
      if (c_valid_ff) begin
         if (cfg.enable) begin
            d_tok_ff.first <= c_first_out_ff;
            if ((c_centre_ff.alpha != 8'd0) || (c_n_ff == '0)) begin
               d_tok_ff.pixel <= c_centre_ff;
            end else begin
               d_tok_ff.pixel <= avg;
            end
         end else begin
            d_tok_ff.first <= c_in_first_ff;
            d_tok_ff.pixel <= c_pixel_ff;
         end
      end
   end

   assign out_valid = d_valid_ff;
   assign out_tok   = d_tok_ff;

endmodule
`default_nettype wire

// File: rtl/transparent_texel_colour_dilation.sv
// transparent texel colour dilation
//
// req_* carries one item per transfer: a pixel in raster order, or a flush
// item (mode 1) that supplies an empty slot to drain the image. rsp_* carries
// the dilated pixels in the same raster order, frame_end on the last one.
// csr_* writes image_width, image_height and pass_count; csr_ready is always
// high, and the geometry is latched at the first pixel of each image.
//
// a pixel's result leaves pass_count*(image_width+1) items after it enters,
// so image_width+1 flush items per pass drain the tail of the image.
// items cannot arrive back to back: req_stall rises after each accepted
// item. each item travels the tok0 register, a chain of MAX_PASSES cells
// (stages a, b, c and d in each) and the result queue before rsp_valid
// rises. unused cells pass tokens through unchanged.
// the first pixel of an image waits until the previous image has left the chain.
// results collect in a FIFO_DEPTH entry queue; req_stall rises when results
// in flight would fill it, so a stalled receiver only ever stalls the sender.
// reset is synchronous: registers return to 256 x 256 x 8 passes and the
// block waits for the first pixel of a new image.
`default_nettype none
module transparent_texel_colour_dilation
   import tcd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_payload,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]       csr_data
);

   // configuration registers
   logic [DIM_W-1:0]      cfg_width_ff, cfg_height_ff;
   logic [PASS_REG_W-1:0] cfg_passes_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= DIM_W'(256);
         cfg_height_ff <= DIM_W'(256);
         cfg_passes_ff <= PASS_REG_W'(8);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: cfg_height_ff <= csr_data;
            CSR_PASS_COUNT:   cfg_passes_ff <= csr_data[PASS_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // geometry for an image that starts with this transfer
   logic [DIM_W-1:0]   new_w, new_h;
   logic [ACT_P_W-1:0] new_p;
   logic [POS_W-1:0]   new_n, new_l, new_end;

   always_comb begin
      if (cfg_width_ff == '0) begin
         new_w = DIM_W'(1);
      end else if (cfg_width_ff > DIM_W'(MAX_WIDTH)) begin
         new_w = DIM_W'(MAX_WIDTH);
      end else begin
         new_w = cfg_width_ff;
      end
      if (cfg_height_ff == '0) begin
         new_h = DIM_W'(1);
      end else if (cfg_height_ff > DIM_W'(MAX_HEIGHT)) begin
         new_h = DIM_W'(MAX_HEIGHT);
      end else begin
         new_h = cfg_height_ff;
      end
      if (ACT_P_W'(cfg_passes_ff) > ACT_P_W'(MAX_PASSES)) begin
         new_p = ACT_P_W'(MAX_PASSES);
      end else begin
         new_p = ACT_P_W'(cfg_passes_ff);
      end
      new_n   = POS_W'(new_w * new_h);
      new_l   = POS_W'(POS_W'(new_p) * (POS_W'(new_w) + POS_W'(1)));
      new_end = new_n + new_l - POS_W'(1);
   end

   // slot sequencing
   logic [POS_W-1:0]   slot_ff;
   logic [DIM_W-1:0]   act_w_ff, act_h_ff;
   logic [ACT_P_W-1:0] act_p_ff;
   logic [POS_W-1:0]   act_n_ff, act_l_ff, act_end_ff;
   logic [POS_W-1:0]   cur_n, cur_l, cur_end;
   logic               gap_ff;
   logic               busy_ff;
   logic [FIFO_AW:0]   pending_ff;
   logic               accept, start, launch, emit, last_slot, pop;

   // a new image holds until the last one has drained out of the chain
   assign req_stall = gap_ff || (pending_ff == (FIFO_AW+1)'(FIFO_DEPTH)) ||
                      (start && busy_ff);
   assign accept    = req_valid && !req_stall;
   assign start     = slot_ff == '0;
   // a flush with no image under way is dropped
   assign launch    = accept && !(start && req_payload.mode);
   assign cur_n     = start ? new_n : act_n_ff;
   assign cur_l     = start ? new_l : act_l_ff;
   assign cur_end   = start ? new_end : act_end_ff;
   assign emit      = slot_ff >= cur_l;
   assign last_slot = slot_ff == cur_end;

   logic      tok0_valid_ff;
   token_type tok0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff       <= '0;
         gap_ff        <= 1'b0;
         tok0_valid_ff <= 1'b0;
         pending_ff    <= '0;
      end else begin
         gap_ff        <= accept;
         tok0_valid_ff <= launch;
         if (launch) begin
            slot_ff <= last_slot ? '0 : slot_ff + POS_W'(1);
         end
         pending_ff <= pending_ff + (FIFO_AW+1)'(launch && emit) - (FIFO_AW+1)'(pop);
      end
      if (launch) begin
         tok0_ff.first <= start;
         // pixels past the end of the image act as flushes, and flushes are black
         if ((slot_ff < cur_n) && !req_payload.mode) begin
            tok0_ff.pixel <= {req_payload.in_alpha, req_payload.in_blue,
                              req_payload.in_green, req_payload.in_red};
         end else begin
            tok0_ff.pixel <= '0;
         end
         if (start) begin
            act_w_ff   <= new_w;
            act_h_ff   <= new_h;
            act_p_ff   <= new_p;
            act_n_ff   <= new_n;
            act_l_ff   <= new_l;
            act_end_ff <= new_end;
         end
      end
   end

   // chain of pass cells
   logic      chain_valid [MAX_PASSES+1];
   token_type chain_tok   [MAX_PASSES+1];

   assign chain_valid[0] = tok0_valid_ff;
   assign chain_tok[0]   = tok0_ff;

   for (genvar k = 0; k < MAX_PASSES; k++) begin : g_cell
      cell_cfg_type cell_cfg;
      assign cell_cfg.width  = act_w_ff;
      assign cell_cfg.height = act_h_ff;
      assign cell_cfg.enable = ACT_P_W'(k) < act_p_ff;
      tcd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cfg       (cell_cfg),
         .in_valid  (chain_valid[k]),
         .in_tok    (chain_tok[k]),
         .out_valid (chain_valid[k+1]),
         .out_tok   (chain_tok[k+1])
      );
   end

   // result queue
   rsp_type          fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]   count_ff;
   logic [POS_W-1:0]   out_pos_ff;
   logic               push, frame_last;
   pixel_type          push_pixel;

   assign push       = chain_valid[MAX_PASSES];
   assign push_pixel = chain_tok[MAX_PASSES].pixel;
   assign frame_last = out_pos_ff == act_n_ff - POS_W'(1);
   assign rsp_valid  = count_ff != '0;
   assign pop        = rsp_valid && !rsp_stall;
   assign rsp_payload = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
         out_pos_ff <= '0;
         busy_ff    <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff  <= wr_ptr_ff + FIFO_AW'(1);
            out_pos_ff <= frame_last ? '0 : out_pos_ff + POS_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         count_ff <= count_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
         // an image is in the chain from its first slot to its last result
         if (push && frame_last) begin
            busy_ff <= 1'b0;
         end else if (launch && start) begin
            busy_ff <= 1'b1;
         end
      end
      if (push) begin
         fifo_ff[wr_ptr_ff].out_red   <= push_pixel.red;
         fifo_ff[wr_ptr_ff].out_green <= push_pixel.green;
         fifo_ff[wr_ptr_ff].out_blue  <= push_pixel.blue;
         fifo_ff[wr_ptr_ff].out_alpha <= push_pixel.alpha;
         fifo_ff[wr_ptr_ff].frame_end <= frame_last;
      end
   end

endmodule
`default_nettype wire

// File: bench/tcd_checker.sv
`timescale 1ns / 1ps
module tcd_checker
   import tcd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire req_type                req_payload,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire rsp_type                rsp_payload,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]       csr_data,
   output int                          mismatches,
   output int                          pending
);

   localparam int RING = 2 * MAX_WIDTH + 4;

   // one line ring per pass level, level 0 holds the input image
   pixel_type   lines [0:MAX_PASSES][0:RING-1];
   int unsigned slot;
   int unsigned width_reg, height_reg, passes_reg;
   int unsigned cur_w, cur_h, cur_p;
   rsp_type     dilated_q[$];

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic pixel_type dilate(int unsigned lvl, int unsigned q);
      pixel_type   centre, nb;
      int unsigned x, y, r, g, b, n;
      int          nx, ny;
      centre = lines[lvl-1][q % RING];
      if (centre.alpha != 0) return centre;
      x = q % cur_w;
      y = q / cur_w;
      r = 0; g = 0; b = 0; n = 0;
      for (int dy = -1; dy <= 1; dy++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            nx = int'(x) + dx;
            ny = int'(y) + dy;
            if (nx < 0 || ny < 0 || nx >= int'(cur_w) || ny >= int'(cur_h)) continue;
            nb = lines[lvl-1][(ny * cur_w + nx) % RING];
            // transparent black neighbors do not vote
            if (nb == '0) continue;
            r += nb.red; g += nb.green; b += nb.blue;
            n++;
         end
      end
      if (n == 0) return centre;
      return '{alpha: 8'd0, blue: 8'(b / n), green: 8'(g / n), red: 8'(r / n)};
   endfunction

   task automatic take_item(input req_type it);
      pixel_type   pix, p;
      int unsigned s, npix, lat, d, q;
      bit          last;
      rsp_type     exp_item;
      pix = '{alpha: it.in_alpha, blue: it.in_blue, green: it.in_green, red: it.in_red};
      s = slot;
      if (s == 0) begin
         // flush on an idle block is dropped
         if (it.mode) return;
         cur_w = clamp_dim(width_reg, MAX_WIDTH);
         cur_h = clamp_dim(height_reg, MAX_HEIGHT);
         cur_p = (passes_reg > MAX_PASSES) ? MAX_PASSES : passes_reg;
      end
      npix = cur_w * cur_h;
      lat  = cur_p * (cur_w + 1);
      if (s < npix) lines[0][s % RING] = it.mode ? pixel_type'('0) : pix;
      for (int unsigned k = 1; k <= cur_p; k++) begin
         d = k * (cur_w + 1);
         if (s >= d && s - d < npix) lines[k][(s - d) % RING] = dilate(k, s - d);
      end
      if (s >= lat) begin
         q = s - lat;
         p = lines[cur_p][q % RING];
         last = (q + 1 >= npix);
         exp_item = '{out_red: p.red, out_green: p.green, out_blue: p.blue,
                      out_alpha: p.alpha, frame_end: last};
         dilated_q.insert(dilated_q.size(), exp_item);
         slot = last ? 0 : s + 1;
      end else begin
         slot = s + 1;
      end
   endtask

   task automatic report(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: want r=%0d g=%0d b=%0d a=%0d end=%0d got r=%0d g=%0d b=%0d a=%0d end=%0d",
                  $realtime, what, want.out_red, want.out_green, want.out_blue,
                  want.out_alpha, want.frame_end, got.out_red, got.out_green,
                  got.out_blue, got.out_alpha, got.frame_end);
   endtask

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         slot = 0;
         width_reg = MAX_WIDTH; height_reg = MAX_HEIGHT; passes_reg = MAX_PASSES;
         cur_w = 1; cur_h = 1; cur_p = 0;
         for (int i = 0; i <= MAX_PASSES; i++)
            for (int j = 0; j < RING; j++) lines[i][j] = '0;
         dilated_q.delete();
      end else begin
         // an item in the same cycle as a register write sees the old value
         if (req_valid && !req_stall) take_item(req_payload);
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_IMAGE_WIDTH:  width_reg  = csr_data;
               CSR_IMAGE_HEIGHT: height_reg = csr_data;
               CSR_PASS_COUNT:   passes_reg = csr_data[PASS_REG_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (dilated_q.size() == 0) begin
               report("unexpected transfer", '0, rsp_payload);
            end else begin
               want = dilated_q.pop_front();
               if (rsp_payload !== want) report("mismatch", want, rsp_payload);
            end
         end
      end
      pending = dilated_q.size();
   end

endmodule

// File: bench/tb_transparent_texel_colour_dilation.sv
`timescale 1ns / 1ps
module tb_transparent_texel_colour_dilation;
   import tcd_pkg::*;

   localparam int LIMIT      = 1000000;  // cycles before the run is declared hung
   localparam int SETTLE     = 60;       // margin for the pipe to empty after the last result
   localparam int RAND_ITEMS = 1150;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]       csr_data = '0;

   int mismatches, pending;
   int cycles = 0;
   bit quiet = 1'b0;        // no sender gaps while set
   int rsp_transfers = 0;

   transparent_texel_colour_dilation dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   tcd_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .mismatches(mismatches), .pending(pending)
   );

   initial forever #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("** transparent_texel_colour_dilation: FAILED **");
         $finish;
      end
   end

   // gap lengths: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // receiver stalls, with one long hold-off once traffic is going so the
   // internal queue fills and the block stalls its input
   initial begin
      int  left;
      bit  held;
      left = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && rsp_transfers >= 150) begin
            held = 1'b1;
            left = 500;
         end
         if (left > 0) begin
            left--;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            left = pick_gap();
            rsp_stall <= (left > 0);
            if (left > 0) left--;
         end
      end
   end

   always @(posedge clock)
      if (rsp_valid && !rsp_stall) rsp_transfers <= rsp_transfers + 1;

   // one item transfer on the request channel
   task automatic send(input req_type it);
      int gap;
      gap = quiet ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [DIM_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for every expected result, then let the pipe empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(input int w, input int h, input int p);
      settle();
      csr_write(CSR_IMAGE_WIDTH, w[DIM_W-1:0]);
      csr_write(CSR_IMAGE_HEIGHT, h[DIM_W-1:0]);
      csr_write(CSR_PASS_COUNT, DIM_W'(p[PASS_REG_W-1:0]));
   endtask

   function automatic req_type pixel(input int r, input int g, input int b, input int a);
      return '{mode: 1'b0, in_red: 8'(r), in_green: 8'(g), in_blue: 8'(b),
               in_alpha: 8'(a)};
   endfunction

   function automatic req_type flush_item();
      req_type it;
      it = '{default: '0};
      it.in_red = 8'($urandom);
      it.mode = 1'b1;
      return it;
   endfunction

   // mostly transparent or black pixels so dilation has work to do
   function automatic req_type random_pixel();
      int      r;
      req_type it;
      r  = $urandom_range(0, 99);
      it = pixel($urandom, $urandom, $urandom, $urandom);
      if (r < 40) it.in_alpha = '0;
      else if (r < 60) it = pixel(0, 0, 0, 0);
      return it;
   endfunction

   function automatic int eff(input int v, input int maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
   endfunction

   // one full image of random content; returns the items that counted
   task automatic random_image(input int w, input int h, input int p, output int used);
      int npix, lat;
      npix = eff(w % 512, MAX_WIDTH) * eff(h % 512, MAX_HEIGHT);
      lat  = ((p % 16) > MAX_PASSES ? MAX_PASSES : p % 16) * (eff(w % 512, MAX_WIDTH) + 1);
      configure(w, h, p);
      // a flush on an idle block is dropped
      if ($urandom_range(0, 3) == 0) send(flush_item());
      send(random_pixel());
      for (int i = 1; i < npix + lat; i++) begin
         // flush inside the image acts as black; pixel past the end acts as flush
         if (i < npix) send($urandom_range(0, 19) == 0 ? flush_item() : random_pixel());
         else send($urandom_range(0, 9) == 0 ? random_pixel() : flush_item());
      end
      used = npix + lat;
   endtask

   initial begin
      int total, used;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: 3x3, one pass, opaque, black, transparent and extreme pixels
      configure(3, 3, 1);
      send(flush_item());
      send(pixel(255, 255, 255, 255));
      send(pixel(0, 0, 0, 0));
      send(pixel(10, 20, 30, 0));
      send(pixel(0, 0, 0, 0));
      send(pixel(0, 0, 0, 0));
      send(pixel(255, 0, 128, 0));
      send(pixel(1, 2, 3, 128));
      send(pixel(0, 0, 0, 0));
      send(pixel(0, 0, 0, 0));
      repeat (4) send(flush_item());
      // 2x2, two passes: no qualifying neighbor, flush mid-image, pixel after end
      configure(2, 2, 2);
      send(pixel(0, 0, 0, 0));
      send(flush_item());
      send(pixel(0, 0, 0, 0));
      send(pixel(255, 255, 255, 0));
      send(pixel(9, 9, 9, 9));
      repeat (5) send(flush_item());

      // register extremes: zero sizes, oversize saturation, widest and tallest
      total = 0;
      random_image(0, 0, 15, used);
      total += used;
      random_image(511, 1, 1, used);
      total += used;
      random_image(1, 511, 1, used);
      total += used;
      random_image(4, 3, 0, used);
      total += used;

      // random images, mostly small
      while (total < RAND_ITEMS) begin
         quiet = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0)
            random_image($urandom_range(1, 40), $urandom_range(1, 3),
                         $urandom_range(0, 15), used);
         else
            random_image($urandom_range(1, 10), $urandom_range(1, 8),
                         $urandom_range(0, 3), used);
         total += used;
      end
      quiet = 1'b0;

      settle();
      if (mismatches == 0 && pending == 0)
         $display("** transparent_texel_colour_dilation: PASSED **");
      else
         $display("** transparent_texel_colour_dilation: FAILED **");
      $finish;
   end

endmodule

// File: filelist.f
rtl/tcd_pkg.sv
rtl/tcd_ram.sv
rtl/tcd_cell.sv
rtl/transparent_texel_colour_dilation.sv
bench/tcd_checker.sv
bench/tb_transparent_texel_colour_dilation.sv
